// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Same-cycle implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_CLKD(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/lfu_pkg.sv =====
package lfu_pkg;

  // Cache geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int USES_W  = 32;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [USES_W-1:0] USES_MAX  = '1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);

  // Request kinds
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic             start;    // latch request, clear scan results
    logic             rd_en;    // read one entry of the tables
    logic [IDX_W-1:0] rd_addr;
    logic             commit;   // apply update and load the result register
  } lfu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;             // result register can take a new result
  } lfu_status_t;

endpackage

// ===== design/lfu_ifs.sv =====
// Request channel: op, key, value
interface lfu_req_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

// Response channel: hit, read_value, evicted
interface lfu_rsp_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

// Capacity register write channel
interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;
  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== design/lfu_ctrl.sv =====
`include "assert_macros.svh"

module lfu_ctrl import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lfu_status_t st,
  output lfu_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.rd_addr = cnt;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
          cnt_next   = '0;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      // last entry is compared in this cycle
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // A scan always starts at entry 0 right after the transaction
  `ASSERT_CLKD(a_scan_starts, clk, rst, cmd.start |=> cmd.rd_en && (cmd.rd_addr == '0))
  // The last read is followed by the drain cycle, then the commit wait
  `ASSERT_CLKD(a_scan_ends, clk, rst, cmd.rd_en && (cmd.rd_addr == LAST_IDX) |=> !cmd.rd_en ##1 !cmd.rd_en)
  // After a commit the controller is ready for the next request
  `ASSERT_CLKD(a_commit_idle, clk, rst, cmd.commit |=> in_ready)

endmodule

// ===== design/lfu_dp.sv =====
`include "assert_macros.svh"

module lfu_dp import lfu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lfu_cmd_t          cmd,
  output lfu_status_t       st,
  input  logic              in_op,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_value,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_cap,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_value,
  output logic              out_evicted
);

  // Entry tables
  logic [KEY_W-1:0]   mem_key   [ENTRIES];
  logic [DATA_W-1:0]  mem_data  [ENTRIES];
  logic [USES_W-1:0]  mem_uses  [ENTRIES];
  logic [STAMP_W-1:0] mem_stamp [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [CAP_W-1:0]   cap;
  logic [STAMP_W-1:0] touch_clock;

  // Registered table read
  logic [KEY_W-1:0]   rd_key;
  logic [DATA_W-1:0]  rd_data;
  logic [USES_W-1:0]  rd_uses;
  logic [STAMP_W-1:0] rd_stamp;
  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;

  // Latched request and scan results
  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [DATA_W-1:0]  val_q;
  logic [CNT_W-1:0]   fill;
  logic               hit;
  logic [IDX_W-1:0]   found_idx;
  logic [DATA_W-1:0]  found_data;
  logic [USES_W-1:0]  found_uses;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic               any;
  logic [IDX_W-1:0]   vic_idx;
  logic [USES_W-1:0]  vic_uses;
  logic [STAMP_W-1:0] vic_stamp;

  // Commit decode
  logic [CNT_W-1:0]   cap_sat;
  logic               need_evict;
  logic               do_insert;
  logic [IDX_W-1:0]   wr_idx;
  logic [USES_W-1:0]  uses_inc;
  logic               wr_key_en;
  logic               wr_data_en;
  logic               wr_meta_en;
  logic [DATA_W-1:0]  wr_data;
  logic [USES_W-1:0]  wr_uses;

  always_comb begin
    cap_sat    = (int'(cap) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cap);
    need_evict = (fill >= cap_sat);
    do_insert  = !hit && (op_q == OP_PUT) && (cap_sat != '0);
    wr_idx     = hit ? found_idx : (need_evict ? vic_idx : free_idx);
    uses_inc   = (found_uses == USES_MAX) ? found_uses : found_uses + USES_W'(1);
    wr_key_en  = cmd.commit && do_insert;
    wr_data_en = cmd.commit && (do_insert || (hit && (op_q == OP_PUT)));
    wr_meta_en = cmd.commit && (do_insert || hit);
    wr_data    = val_q;
    wr_uses    = hit ? uses_inc : USES_W'(1);
    st.out_free = !out_valid || out_ready;
  end

  // Table write and read ports
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      mem_key[wr_idx] <= key_q;
    end
    if (wr_data_en) begin
      mem_data[wr_idx] <= wr_data;
    end
    if (wr_meta_en) begin
      mem_uses[wr_idx]  <= wr_uses;
      mem_stamp[wr_idx] <= touch_clock;
    end
    if (cmd.rd_en) begin
      rd_key   <= mem_key[cmd.rd_addr];
      rd_data  <= mem_data[cmd.rd_addr];
      rd_uses  <= mem_uses[cmd.rd_addr];
      rd_stamp <= mem_stamp[cmd.rd_addr];
      cmp_idx  <= cmd.rd_addr;
    end
  end

  // Valid bits, capacity, touch clock, compare strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      cap         <= CAP_RESET;
      touch_clock <= '0;
      cmp_en      <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
      if (cfg_we) begin
        cap <= cfg_cap;
      end
      if (wr_key_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (wr_meta_en) begin
        touch_clock <= touch_clock + STAMP_W'(1);
      end
    end
  end

  // Scan step: one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      any       <= 1'b0;
    end else if (cmd.start) begin
      op_q      <= in_op;
      key_q     <= in_key;
      val_q     <= in_value;
      fill      <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      any       <= 1'b0;
    end else if (cmp_en) begin
      if (valid[cmp_idx]) begin
        fill <= fill + CNT_W'(1);
        if (!hit && (rd_key == key_q)) begin
          hit        <= 1'b1;
          found_idx  <= cmp_idx;
          found_data <= rd_data;
          found_uses <= rd_uses;
        end
        // lowest count, then oldest stamp
        if (!any || ({rd_uses, rd_stamp} < {vic_uses, vic_stamp})) begin
          any       <= 1'b1;
          vic_idx   <= cmp_idx;
          vic_uses  <= rd_uses;
          vic_stamp <= rd_stamp;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_idx  <= cmp_idx;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit        <= hit;
      out_read_value <= (hit && (op_q == OP_GET)) ? found_data : '0;
      out_evicted    <= do_insert && need_evict;
    end
  end

  // A commit always presents a result in the next cycle
  `ASSERT_CLKD(a_commit_result, clk, rst, cmd.commit |=> out_valid)
  // Read data only ever comes from a hit
  `ASSERT_IMPL(a_read_needs_hit, clk, rst, out_valid && (out_read_value != '0), out_hit)
  // A hit never evicts
  `ASSERT_IMPL(a_hit_no_evict, clk, rst, out_valid && out_hit, !out_evicted)
  // An eviction needs a victim found by the scan
  `ASSERT_IMPL(a_evict_victim, clk, rst, wr_key_en && need_evict, any)

endmodule

// ===== design/lfu_cache_get_put.sv =====
// LFU key-value cache, 16 entries, least recently touched breaks count ties.
// Channels (valid/ready, a transaction completes when both are high):
//   req: op (0 get, 1 put), 32-bit key, 32-bit value.
//   rsp: hit, read_value (value on a get hit, else 0), evicted.
//   cfg: capacity_in_use, always ready; write it only while no request is
//        in flight and the response channel is empty.
// Each request is processed alone: the transaction is taken, the table
// scan reads every entry in turn through the single table read port, the
// last entry is compared, and the commit step applies the update and
// loads the response register. A new request is taken only after the
// previous one has committed.
// The response register decouples the sides: the next request is taken
// while a response waits; if the receiver stalls, the new request finishes
// its scan and holds at commit until the response register frees.
// Reset (synchronous, active high): all entries invalid, touch clock zero,
// capacity 16, no response pending. No clearing pass is needed.
module lfu_cache_get_put import lfu_pkg::*; (
  input  logic clk,
  input  logic rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink   cfg
);

  lfu_cmd_t    cmd;
  lfu_status_t st;

  assign cfg.ready = 1'b1;

  // Sequencer
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Tables, scan logic, response register
  lfu_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .in_op          (req.op),
    .in_key         (req.key),
    .in_value       (req.value),
    .cfg_we         (cfg.valid),
    .cfg_cap        (cfg.capacity_in_use),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_hit        (rsp.hit),
    .out_read_value (rsp.read_value),
    .out_evicted    (rsp.evicted)
  );

endmodule

// ===== test/tb_lfu_cache_get_put.sv =====
`timescale 1ns / 100ps

module tb_lfu_cache_get_put import lfu_pkg::*; ();

  // Expected-response tracking: shadow copy of the cache tables plus the FIFO
  // of responses still owed by the block
  class lfu_scoreboard;
    typedef struct packed {
      bit              hit;
      bit [DATA_W-1:0] read_value;
      bit              evicted;
    } lfu_result_t;

    bit                live[ENTRIES];
    bit [KEY_W-1:0]    keys[ENTRIES];
    bit [DATA_W-1:0]   data[ENTRIES];
    bit [USES_W-1:0]   uses[ENTRIES];
    bit [STAMP_W-1:0]  stamp[ENTRIES];
    bit [STAMP_W-1:0]  touch_clock;
    bit [CAP_W-1:0]    capacity;
    lfu_result_t       pending_responses[$];
    int                errors;
    int                requests;
    int                hits;
    int                evictions;
    int                cap_writes;

    function new();
      capacity    = CAP_RESET;
      touch_clock = '0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void set_capacity(bit [CAP_W-1:0] c);
      capacity = c;
      cap_writes++;
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    // Hit: bump the use count (saturating) and restamp
    function void touch(int i);
      if (uses[i] != USES_MAX) uses[i]++;
      stamp[i] = touch_clock;
      touch_clock++;
    endfunction

    // Apply one accepted request to the shadow tables, queue its response
    function void note_request(bit op, bit [KEY_W-1:0] key, bit [DATA_W-1:0] value);
      lfu_result_t res;
      int          limit;
      int          fill;
      int          found;
      int          free_slot;
      int          slot;
      int          victim;
      bit          is_hit;
      bit          have_free;
      res       = '0;
      limit     = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
      fill      = 0;
      found     = 0;
      free_slot = 0;
      is_hit    = 1'b0;
      have_free = 1'b0;
      requests++;

      // lookup and fill count in one pass
      for (int i = 0; i < ENTRIES; i++) begin
        if (live[i]) begin
          fill++;
          if (!is_hit && keys[i] == key) begin
            is_hit = 1'b1;
            found  = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end

      if (is_hit) begin
        if (op == OP_GET) res.read_value = data[found];
        else data[found] = value;
        touch(found);
        hits++;
      end else if (op == OP_PUT && limit != 0) begin
        slot = free_slot;
        // full: lowest count goes, oldest stamp breaks ties
        if (fill >= limit || !have_free) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && (victim < 0 || uses[i] < uses[victim] ||
                (uses[i] == uses[victim] && stamp[i] < stamp[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            live[victim] = 1'b0;
            res.evicted  = 1'b1;
            slot         = victim;
            evictions++;
          end
        end
        live[slot]  = 1'b1;
        keys[slot]  = key;
        data[slot]  = value;
        uses[slot]  = 1;
        stamp[slot] = touch_clock;
        touch_clock++;
      end

      res.hit = is_hit;
      pending_responses.push_back(res);
    endfunction

    // Compare one accepted response against the oldest expectation
    function void check_response(logic hit, logic [DATA_W-1:0] read_value, logic evicted);
      lfu_result_t want;
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t ERROR: unexpected response hit %b read_value %h evicted %b",
                 $time, hit, read_value, evicted);
        return;
      end
      want = pending_responses.pop_front();
      if (hit !== want.hit) begin
        errors++;
        $display("%0t ERROR: hit expected %b actual %b", $time, want.hit, hit);
      end
      if (read_value !== want.read_value) begin
        errors++;
        $display("%0t ERROR: read_value expected %h actual %h",
                 $time, want.read_value, read_value);
      end
      if (evicted !== want.evicted) begin
        errors++;
        $display("%0t ERROR: evicted expected %b actual %b", $time, want.evicted, evicted);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lfu_req_if req ();
  lfu_rsp_if rsp ();
  lfu_cfg_if cfg ();

  lfu_cache_get_put DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  lfu_scoreboard sb = new();

  int             tx_idle_pct;
  int             rx_idle_pct;
  int             rsp_hold_cycles;
  bit [KEY_W-1:0] key_pool[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_lfu_cache_get_put failed");
    $finish;
  end

  // Response side: random back-pressure, plus long stalls on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_response(rsp.hit, rsp.read_value, rsp.evicted);
      if (req.valid && req.ready)
        sb.note_request(req.op, req.key, req.value);
    end
  end

  // Offer one request; returns right after the accepting edge, valid left high
  task automatic send_request(input bit op, input bit [KEY_W-1:0] key,
                              input bit [DATA_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every response is back
  task automatic wait_for_drain();
    @(negedge clk);
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input bit [CAP_W-1:0] c);
    wait_for_drain();
    @(negedge clk);
    cfg.valid           <= 1'b1;
    cfg.capacity_in_use <= c;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_capacity(c);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Keys for one phase: a few more than fit, so hits and evictions both occur
  task automatic build_key_pool(input int limit);
    int n;
    n = ((limit > ENTRIES) ? ENTRIES : limit) + 3;
    key_pool.delete();
    repeat (n) begin
      case ($urandom_range(7))
        0:       key_pool.push_back('0);
        1:       key_pool.push_back('1);
        default: key_pool.push_back($urandom);
      endcase
    end
  endtask

  task automatic send_random();
    bit [KEY_W-1:0] key;
    if ($urandom_range(99) < 10) key = $urandom;
    else key = key_pool[$urandom_range(key_pool.size() - 1)];
    send_request(($urandom_range(99) < 50) ? OP_PUT : OP_GET, key, $urandom);
  endtask

  bit [CAP_W-1:0] phase_caps[7] = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd7, 5'd12};

  initial begin
    rst                 = 1'b1;
    req.valid           = 1'b0;
    req.op              = OP_GET;
    req.key             = '0;
    req.value           = '0;
    cfg.valid           = 1'b0;
    cfg.capacity_in_use = '0;
    rsp_hold_cycles     = 0;
    tx_idle_pct         = 26;
    rx_idle_pct         = 55;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty miss, extreme keys/values, get and put hits
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
    // capacity 2 while holding 2: evict by lowest count
    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
    send_request(OP_PUT, 32'h0000_0002, 32'h5A5A_5A5A);
    send_request(OP_PUT, 32'h0000_0003, 32'h0000_0003);
    // equal counts: least recently touched goes
    write_capacity(5'd3);
    send_request(OP_PUT, 32'h0000_0004, 32'h0000_0004);
    send_request(OP_PUT, 32'h0000_0005, 32'h0000_0005);
    send_request(OP_GET, 32'h0000_0004, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0006, 32'h0000_0006);
    // zero capacity stores nothing
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h0000_0007, 32'h0000_0007);
    send_request(OP_GET, 32'h0000_0007, 32'h0000_0000);
    // capacity above the table size saturates
    write_capacity(5'd31);
    send_request(OP_PUT, 32'h8000_0000, 32'h8000_0001);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);

    // Random phases over several capacities, idle mix changes as we go
    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        tx_idle_pct = 55;
        rx_idle_pct = 26;
      end else if (p == 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_capacity(phase_caps[p]);
      build_key_pool(phase_caps[p]);
      for (int n = 0; n < 200; n++) begin
        // long response stall while requests keep coming
        if ((p == 1 || p == 5) && n == 60) rsp_hold_cycles = 400;
        // sender pause until the block has fully drained
        if (p == 2 && n == 100) wait_for_drain();
        send_random();
      end
    end

    wait_for_drain();
    repeat (25) @(posedge clk);

    $display("Covered %0d requests: %0d hits, %0d evictions, %0d capacity writes",
             sb.requests, sb.hits, sb.evictions, sb.cap_writes);
    $display("Idle mixes: sender-light, receiver-light, none; two long response stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_lfu_cache_get_put passed");
    end else begin
      $display("tb_lfu_cache_get_put failed");
    end
    $finish;
  end

endmodule
